// ===== rtl/assert_macros.svh =====
// assertion macros for the timer deadline table
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

// ===== rtl/tdt_pkg.sv =====
// shared constants, codes and control structs of the timer deadline table
// no dependencies
`default_nettype none
package tdt_pkg;
    localparam int SLOTS     = 16;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int TIME_BITS = 32;

    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_DISARM = 2'd1,
        OP_TICK   = 2'd2,
        OP_POLL   = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic apply;
        logic scan_start;
        logic unlink;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic is_poll;
        logic hit_found;
        logic fired;
        logic out_free;
    } status_t;
endpackage
`default_nettype wire

// ===== rtl/tdt_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module tdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/tdt_ctrl.sv =====
// sequencer of the timer deadline table
// depends on tdt_pkg
`default_nettype none
module tdt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tdt_pkg::status_t st,
    output tdt_pkg::cmd_t         cmd
);
    import tdt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_APPLY  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_UNLINK = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply      = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (st.scan_done)
                begin
                    if (st.is_poll && st.hit_found && !st.fired)
                        state_next = S_UNLINK;
                    else
                        state_next = S_OUT;
                end
            end
            S_UNLINK:
            begin
                cmd.unlink     = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ===== rtl/tdt_dp.sv =====
// datapath of the timer deadline table: slot flags, list ranks, deadline scan
// depends on tdt_pkg and tdt_ram
`default_nettype none
module tdt_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tdt_pkg::cmd_t                     cmd,
    output tdt_pkg::status_t                       st,
    input  wire logic [1:0]                        operation,
    input  wire logic [3:0]                        slot,
    input  wire logic [31:0]                       delay,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [31:0]                            earliest_delay,
    output logic                                   alarm_armed,
    output logic                                   fired,
    output logic [3:0]                             fired_slot
);
    import tdt_pkg::*;

    op_t                  op_reg;
    logic [3:0]           slot_reg;
    logic [TIME_BITS-1:0] delay_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [SLOTS-1:0]     armed_reg;
    logic [SLOT_BITS-1:0] rank_reg [SLOTS];
    logic                 scan_on_reg;
    logic [SLOT_BITS-1:0] scan_idx_reg;
    logic                 rd_vld_reg;
    logic [SLOT_BITS-1:0] rd_idx_reg;
    logic [TIME_BITS-1:0] min_reg;
    logic                 any_reg;
    logic                 found_reg;
    logic [SLOT_BITS-1:0] hit_reg;
    logic [SLOT_BITS-1:0] hit_rank_reg;
    logic                 fired_reg;
    logic                 out_valid_reg;
    logic [31:0]          out_delay_reg;
    logic                 out_armed_reg;
    logic                 out_fired_reg;
    logic [3:0]           out_slot_reg;

    logic                 slot_ok;
    logic [SLOT_BITS-1:0] sidx;
    logic                 arm_new;
    logic                 do_unlink;
    logic [SLOT_BITS-1:0] unl_slot;
    logic [SLOT_BITS-1:0] unl_rank;
    logic                 ram_we;
    logic [TIME_BITS-1:0] rdata;
    logic [TIME_BITS-1:0] remain;
    logic                 expired;
    logic [TIME_BITS-1:0] rem_eff;

    assign slot_ok  = ({1'b0, slot_reg} < 5'(SLOTS));
    assign sidx     = SLOT_BITS'(slot_reg);
    assign ram_we   = cmd.apply && (op_reg == OP_ARM) && slot_ok;
    assign arm_new  = ram_we && !armed_reg[sidx];
    assign do_unlink = cmd.unlink ||
        (cmd.apply && (op_reg == OP_DISARM) && slot_ok && armed_reg[sidx]);
    assign unl_slot = cmd.unlink ? hit_reg : sidx;
    assign unl_rank = rank_reg[unl_slot];

    tdt_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_deadline (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sidx),
        .wdata (time_reg + delay_reg),
        .raddr (scan_idx_reg),
        .rdata (rdata)
    );

    assign remain  = rdata - time_reg;
    assign expired = (remain == '0) || remain[TIME_BITS-1];
    assign rem_eff = expired ? '0 : remain;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(operation);
            slot_reg  <= slot;
            delay_reg <= TIME_BITS'(delay);
        end
        for (int j = 0; j < SLOTS; j++)
        begin
            if (arm_new)
            begin
                if (j == int'(sidx))
                    rank_reg[j] <= '0;
                else if (armed_reg[j])
                    rank_reg[j] <= rank_reg[j] + 1'b1;
            end
            else if (do_unlink && armed_reg[j] && (rank_reg[j] > unl_rank))
            begin
                rank_reg[j] <= rank_reg[j] - 1'b1;
            end
        end
        rd_idx_reg <= scan_idx_reg;
        if (cmd.scan_start)
        begin
            min_reg   <= '1;
            any_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (rd_vld_reg && armed_reg[rd_idx_reg])
        begin
            any_reg <= 1'b1;
            if (rem_eff < min_reg)
                min_reg <= rem_eff;
            if (expired && !fired_reg &&
                (!found_reg || (rank_reg[rd_idx_reg] < hit_rank_reg)))
            begin
                found_reg    <= 1'b1;
                hit_reg      <= rd_idx_reg;
                hit_rank_reg <= rank_reg[rd_idx_reg];
            end
        end
        if (cmd.out_load)
        begin
            out_delay_reg <= any_reg ? 32'(min_reg) : 32'd0;
            out_armed_reg <= any_reg;
            out_fired_reg <= fired_reg;
            out_slot_reg  <= fired_reg ? 4'(hit_reg) : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            armed_reg     <= '0;
            scan_on_reg   <= 1'b0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            fired_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply && (op_reg == OP_TICK))
                time_reg <= time_reg + 1'b1;
            if (arm_new)
                armed_reg[sidx] <= 1'b1;
            else if (do_unlink)
                armed_reg[unl_slot] <= 1'b0;
            if (cmd.load)
                fired_reg <= 1'b0;
            else if (cmd.unlink)
                fired_reg <= 1'b1;
            rd_vld_reg <= scan_on_reg;
            if (cmd.scan_start)
            begin
                scan_on_reg  <= 1'b1;
                scan_idx_reg <= '0;
            end
            else if (scan_on_reg)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_idx_reg == SLOT_BITS'(SLOTS - 1))
                    scan_on_reg <= 1'b0;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign st.scan_done = !scan_on_reg && !rd_vld_reg;
    assign st.is_poll   = (op_reg == OP_POLL);
    assign st.hit_found = found_reg;
    assign st.fired     = fired_reg;
    assign st.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign earliest_delay = out_delay_reg;
    assign alarm_armed    = out_armed_reg;
    assign fired          = out_fired_reg;
    assign fired_slot     = out_slot_reg;
endmodule
`default_nettype wire

// ===== rtl/multi_timer_deadline_table_top.sv =====
// timer deadline table: an accepted word runs one deadline ram scan at one slot per cycle;
// a poll that fires unlinks the hit slot and scans again before its result is loaded
// the next word is accepted only once the previous result is in the output register
// a finished word waits in the output register while the next word is accepted
// reset clears time, armed flags and handshakes at once; no clearing pass
// depends on tdt_pkg, tdt_ctrl, tdt_dp, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module multi_timer_deadline_table_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [3:0]  slot,
    input  wire logic [31:0] delay,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      earliest_delay,
    output logic             alarm_armed,
    output logic             fired,
    output logic [3:0]       fired_slot
);
    import tdt_pkg::*;

    cmd_t    cmd;
    status_t st;

    tdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    tdt_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .operation      (operation),
        .slot           (slot),
        .delay          (delay),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .earliest_delay (earliest_delay),
        .alarm_armed    (alarm_armed),
        .fired          (fired),
        .fired_slot     (fired_slot)
    );

    `ASSERT_IMPL(a_busy_after_accept, in_valid && in_ready |=> !in_ready)
    `ASSERT_NEVER(a_slot_without_fire, out_valid && !fired && fired_slot != 4'd0)
    `ASSERT_NEVER(a_delay_without_alarm, out_valid && !alarm_armed && earliest_delay != 32'd0)
endmodule
`default_nettype wire
